// ----- rtl/pcfj_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfj_pkg: shared types and constants for the particle color fade core
// Register map, LCG constants, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pcfj_pkg;

	// configuration port
	localparam int AddrW = 5;
	localparam int DataW = 32;

	localparam logic [2:0] RegStartLevel   = 3'd0;
	localparam logic [2:0] RegMidLevel     = 3'd1;
	localparam logic [2:0] RegEndLevel     = 3'd2;
	localparam logic [2:0] RegRiseEnd      = 3'd3;
	localparam logic [2:0] RegFallStart    = 3'd4;
	localparam logic [2:0] RegJitterAmount = 3'd5;

	localparam logic [7:0] FallStartReset = 8'hff;

	// seed generator
	localparam logic [31:0] LcgMul = 32'h5eedf715;
	localparam logic [31:0] LcgAdd = 32'h1b0cb173;

	// divider: 13-bit magnitude numerator, 8-bit divisor, one bit per step
	localparam int NumW     = 13;
	localparam int DivSteps = NumW;
	localparam int CntW     = $clog2(DivSteps);

	typedef struct packed {
		logic [4:0] start_level;
		logic [4:0] mid_level;
		logic [4:0] end_level;
		logic [7:0] rise_end;
		logic [7:0] fall_start;
		logic [7:0] jitter_amount;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_LEVEL,
		ST_SCALE
	} state_t;

	typedef struct packed {
		logic load;      // capture item, advance seed
		logic setup;     // pick segment, load divider, form dim factor
		logic div_step;  // one restoring divide step
		logic level;     // apply quotient to base level
		logic write_out; // scale level, fill output register
	} cmd_t;

	typedef struct packed {
		logic out_busy;  // output register holds an item not yet taken
	} sts_t;

endpackage

// ----- rtl/pcfj_regs.sv -----
// ----------------------------------------------------------------------------
// pcfj_regs: configuration registers
// APB-style slave holding the six envelope and jitter settings.
// ----------------------------------------------------------------------------
module pcfj_regs
	import pcfj_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[AddrW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_level   <= '0;
			cfg_q.mid_level     <= '0;
			cfg_q.end_level     <= '0;
			cfg_q.rise_end      <= '0;
			cfg_q.fall_start    <= FallStartReset;
			cfg_q.jitter_amount <= '0;
		end else if (wr_en) begin
			case (idx)
				RegStartLevel:   cfg_q.start_level   <= pwdata[4:0];
				RegMidLevel:     cfg_q.mid_level     <= pwdata[4:0];
				RegEndLevel:     cfg_q.end_level     <= pwdata[4:0];
				RegRiseEnd:      cfg_q.rise_end      <= pwdata[7:0];
				RegFallStart:    cfg_q.fall_start    <= pwdata[7:0];
				RegJitterAmount: cfg_q.jitter_amount <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegStartLevel:   prdata = {27'd0, cfg_q.start_level};
			RegMidLevel:     prdata = {27'd0, cfg_q.mid_level};
			RegEndLevel:     prdata = {27'd0, cfg_q.end_level};
			RegRiseEnd:      prdata = {24'd0, cfg_q.rise_end};
			RegFallStart:    prdata = {24'd0, cfg_q.fall_start};
			RegJitterAmount: prdata = {24'd0, cfg_q.jitter_amount};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/pcfj_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcfj_ctrl: item sequencer
// Walks one item through setup, the divide steps, level and scale.
// ----------------------------------------------------------------------------
module pcfj_ctrl
	import pcfj_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            last_step;

	assign last_step = (cnt_q == CntW'(DivSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_DIV;
			ST_DIV:   if (last_step) state_d = ST_LEVEL;
			ST_LEVEL: state_d = ST_SCALE;
			ST_SCALE: if (!sts.out_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_LEVEL: cmd.level = 1'b1;
			ST_SCALE: cmd.write_out = !sts.out_busy;
			default: ;
		endcase
	end

	a_idle_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !cmd.div_step && !cmd.write_out)
		else $error("datapath command issued while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> !sts.out_busy)
		else $error("output register overwritten before taken");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && last_step |=> state_q == ST_LEVEL)
		else $error("divider did not finish after its step count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DIV |-> cnt_q == '0)
		else $error("step counter not cleared outside divide");

endmodule

// ----- rtl/pcfj_dp.sv -----
// ----------------------------------------------------------------------------
// pcfj_dp: fade datapath
// Seed LCG, segment select, restoring divider, dimming and output register.
// ----------------------------------------------------------------------------
module pcfj_dp
	import pcfj_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  age,
	input  logic [15:0] old_word,
	output logic [15:0] new_word,
	output logic        out_valid,
	input  logic        out_stall
);

	logic [31:0]     seed_q;
	logic [31:0]     seed_next;
	logic [7:0]      age_q;
	logic [15:0]     word_q;
	logic [NumW-1:0] quo_q;
	logic [7:0]      rem_q;
	logic [7:0]      den_q;
	logic            neg_q;
	logic            zero_q;
	logic [4:0]      base_q;
	logic [7:0]      dim_q;
	logic [4:0]      lvl_q;
	logic [15:0]     new_word_q;
	logic            out_valid_q;

	// setup terms
	logic            in_rise, in_fall;
	logic [5:0]      diff;
	logic [4:0]      diff_mag;
	logic [7:0]      span, den_sel;
	logic [NumW-1:0] num_mag;
	logic [15:0]     jit_prod;
	// divide step
	logic [8:0]      trial, trial_sub;
	logic            fits;
	// level and scale
	logic [4:0]      q5;
	logic [12:0]     scaled;

	assign seed_next = seed_q * LcgMul + LcgAdd;

	always_comb begin
		in_rise  = age_q < cfg.rise_end;
		in_fall  = !in_rise && !(age_q < cfg.fall_start);
		// fall: (age-255)*(end-mid) == (255-age)*(mid-end)
		diff     = in_rise ? ({1'b0, cfg.mid_level} - {1'b0, cfg.start_level})
		                   : ({1'b0, cfg.mid_level} - {1'b0, cfg.end_level});
		diff_mag = diff[5] ? 5'(-diff) : diff[4:0];
		span     = in_rise ? age_q : (8'hff - age_q);
		den_sel  = in_rise ? cfg.rise_end : (8'hff - cfg.fall_start);
		num_mag  = NumW'(span) * NumW'(diff_mag);
		jit_prod = 16'(cfg.jitter_amount) * 16'(seed_q[31:24]);
	end

	always_comb begin
		trial     = {rem_q, quo_q[NumW-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = (trial >= {1'b0, den_q});
		q5        = zero_q ? 5'd0 : quo_q[4:0];
		scaled    = 13'(lvl_q) * 13'(dim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cmd.load) begin
			seed_q <= seed_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			age_q  <= age;
			word_q <= old_word;
		end
		if (cmd.setup) begin
			quo_q  <= num_mag;
			rem_q  <= '0;
			den_q  <= den_sel;
			neg_q  <= diff[5];
			// hold segment, or zero divisor, gives a zero quotient
			zero_q <= !in_rise && (!in_fall || den_sel == 8'd0);
			base_q <= in_rise ? cfg.start_level :
			          (in_fall ? cfg.end_level : cfg.mid_level);
			dim_q  <= ~jit_prod[15:8];
		end
		if (cmd.div_step) begin
			rem_q <= fits ? trial_sub[7:0] : trial[7:0];
			quo_q <= {quo_q[NumW-2:0], fits};
		end
		if (cmd.level) begin
			lvl_q <= neg_q ? (base_q - q5) : (base_q + q5);
		end
		if (cmd.write_out) begin
			new_word_q <= {word_q[15:10], scaled[12:8], word_q[4:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_word     = new_word_q;
	assign sts.out_busy = out_valid_q & out_stall;

	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |=> out_valid)
		else $error("output not valid after write");

	a_seed_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> $stable(seed_q))
		else $error("seed moved without an item");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.setup, cmd.div_step, cmd.level, cmd.write_out}))
		else $error("overlapping datapath commands");

endmodule

// ----- rtl/particle_color_fade_jitter_core.sv -----
// The 13-step restoring divider sets the item rate: a new item is accepted
// only once the previous one has left the scale state.
// A finished result waits in the output register while the next item runs.
// Reset (arst_n low, async): controller idle, output empty, seed 0,
// configuration to defaults (fall_start 255, others 0).
// ----------------------------------------------------------------------------
// particle_color_fade_jitter_core: green fade envelope with random dimming
// Age picks a 5-bit level from a start/mid/end envelope (rise ramp, hold,
// fall ramp). A 32-bit LCG advances each item; its top byte times the jitter
// setting dims the level. The level lands in bits 5..9 of the color word.
// ----------------------------------------------------------------------------
module particle_color_fade_jitter_core
	import pcfj_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// config port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	// item in
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       age,
	input  logic [15:0]      old_word,
	// item out
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      new_word
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// the user must change registers only while no item is in flight; the block itself does not enforce it
	pcfj_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: idle -> setup -> 13 divide steps -> level -> scale
	pcfj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: divider works on magnitudes, sign applied at level step
	pcfj_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.age       (age),
		.old_word  (old_word),
		.new_word  (new_word),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for particle_color_fade_jitter_core
// Drives age/color items with random gaps and output stalls, reprograms the
// fade envelope and jitter over the APB port between idle phases, and checks
// every returned color word against an in-bench model of the green fade.
// ----------------------------------------------------------------------------
module tb
	import pcfj_pkg::*;
();

	localparam int RandItems  = 1350;
	localparam int CycleLimit = 1000000;
	localparam int TailCycles = 40;   // margin after the final drain
	localparam int MaxReports = 20;

	// Tracks config and seed, predicts each color word, checks results in order.
	class fade_tracker;
		cfg_t        cfg;
		logic [31:0] seed;
		logic [15:0] pending_words[$];
		int          errors;
		int          checked;
		int          noted;

		function new();
			cfg = '0;
			cfg.fall_start = FallStartReset;
			seed = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				RegStartLevel:   cfg.start_level   = data[4:0];
				RegMidLevel:     cfg.mid_level     = data[4:0];
				RegEndLevel:     cfg.end_level     = data[4:0];
				RegRiseEnd:      cfg.rise_end      = data[7:0];
				RegFallStart:    cfg.fall_start    = data[7:0];
				RegJitterAmount: cfg.jitter_amount = data[7:0];
				default: ;       // unmapped index: ignored
			endcase
		endfunction

		// signed divide truncating toward zero; zero divisor gives 0
		function int ramp_quotient(int num, int den);
			if (den == 0)
				return 0;
			return num / den;
		endfunction

		function int faded_level(logic [7:0] age);
			int a, s, m, e, lvl;
			a = age;
			s = cfg.start_level;
			m = cfg.mid_level;
			e = cfg.end_level;
			// rise test first, so crossed thresholds favor the rise ramp
			if (a < int'(cfg.rise_end))
				lvl = s + ramp_quotient(a * (m - s), cfg.rise_end);
			else if (a < int'(cfg.fall_start))
				lvl = m;
			else
				lvl = e + ramp_quotient((a - 255) * (e - m), 255 - int'(cfg.fall_start));
			return (lvl < 0) ? 0 : lvl;
		endfunction

		function void note_item(logic [7:0] age, logic [15:0] word);
			int lvl, dim;
			logic [4:0] green;
			lvl = faded_level(age);
			seed = seed * LcgMul + LcgAdd;
			dim = 255 - ((int'(cfg.jitter_amount) * int'(seed[31:24])) >> 8);
			green = 5'((lvl * dim) >> 8);
			pending_words.push_back({word[15:10], green, word[4:0]});
			noted++;
		endfunction

		function void check_word(logic [15:0] actual);
			logic [15:0] want;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: unexpected new_word %h, nothing pending", $time, actual);
				return;
			end
			want = pending_words.pop_front();
			checked++;
			if (actual !== want) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: new_word mismatch, expected %h got %h",
						$time, want, actual);
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	// --- clock, reset, DUT signals ---
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       age = '0;
	logic [15:0]      old_word = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [15:0]      new_word;

	fade_tracker tracker;
	int          cycle_count;
	int          stall_left;
	bit          stall_quiet;     // receiver starts no new stalls while set
	bit          sender_quiet;    // sender inserts no gaps before items while set
	int          config_writes;
	int          phases;
	int          drains;

	particle_color_fade_jitter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.age      (age),
		.old_word (old_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_word (new_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver back-pressure: mostly short stalls, a few long ones,
	// and whole phases that start no new ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result monitor: an item leaves when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_word(new_word);
	end

	// idle cycles before the next item; 0 keeps valid high back to back
	function automatic int sender_gap();
		int r;
		if (sender_quiet)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// offer one item and hold it until the core takes it
	task automatic send_item(input logic [7:0] a, input logic [15:0] w);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		age <= a;
		old_word <= w;
		do @(posedge clk); while (in_stall);
		tracker.note_item(a, w);
	endtask

	// park the sender until every pending result is back and the core is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		drains++;
	endtask

	// APB write: setup cycle, access cycle, then an idle cycle so that
	// back-to-back writes never touch psel twice in one step
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, data);
		config_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] reg_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;   // upper bits set too, the core keeps only its width
	endfunction

	// random subset of registers, now and then an unmapped index
	task automatic reconfigure();
		logic [2:0] idx;
		for (int i = 0; i < 8; i++) begin
			idx = 3'(i);
			if (i > RegJitterAmount) begin
				if ($urandom_range(0, 7) == 0)
					reg_write(idx, $urandom);
			end else if ($urandom_range(0, 1) == 1) begin
				reg_write(idx, reg_value());
			end
		end
	endtask

	// ages cluster on the envelope corners and segment edges
	function automatic logic [7:0] pick_age();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return tracker.cfg.rise_end + 8'($urandom_range(0, 2)) - 8'd1;
			3: return tracker.cfg.fall_start + 8'($urandom_range(0, 2)) - 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int n;
		int rand_items;
		tracker = new();
		stall_quiet = 1'b0;
		sender_quiet = 1'b0;
		rand_items = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: every level 0, fall_start 255, age 255 hits the
		// zero-divisor case of the fall ramp
		send_item(8'd0, 16'h0000);
		send_item(8'd255, 16'hffff);
		send_item(8'd128, 16'h8421);
		drain();

		// full-range levels, several written with junk above the register's width
		reg_write(RegStartLevel, 32'hffff_ffff);
		reg_write(RegMidLevel, 32'hffff_ffe0);
		reg_write(RegEndLevel, 32'h0000_001f);
		reg_write(RegRiseEnd, 32'h0000_01ff);
		reg_write(RegFallStart, 32'hffff_ffff);
		reg_write(RegJitterAmount, 32'h0000_0000);
		send_item(8'd0, 16'h7c1f);
		send_item(8'd254, 16'h03e0);
		send_item(8'd255, 16'h0000);
		send_item(8'd85, 16'hffff);
		drain();

		// strongest dimming
		reg_write(RegJitterAmount, 32'hffff_ffff);
		send_item(8'd0, 16'hffff);
		send_item(8'd255, 16'h0000);
		drain();

		// crossed thresholds: fall_start below rise_end
		reg_write(RegMidLevel, 32'd16);
		reg_write(RegRiseEnd, 32'd200);
		reg_write(RegFallStart, 32'd100);
		send_item(8'd50, 16'h1234);
		send_item(8'd150, 16'hfedc);
		send_item(8'd199, 16'h5555);
		send_item(8'd200, 16'haaaa);
		send_item(8'd255, 16'h0f0f);
		drain();

		// rise ramp disabled, fall ramp over the whole range; unmapped
		// indexes must leave the map alone
		reg_write(RegRiseEnd, 32'h0000_0000);
		reg_write(RegFallStart, 32'h0000_0000);
		reg_write(3'd6, 32'hffff_ffff);
		reg_write(3'd7, 32'h0000_0013);
		send_item(8'd0, 16'h8000);
		send_item(8'd127, 16'h0001);
		send_item(8'd255, 16'hffff);
		drain();

		// random phases, each starting from an idle core with fresh settings
		while (rand_items < RandItems) begin
			drain();
			reconfigure();
			phases++;
			sender_quiet = ($urandom_range(0, 4) == 0);
			stall_quiet <= ($urandom_range(0, 4) == 0);
			n = $urandom_range(20, 120);
			for (int i = 0; i < n; i++) begin
				// occasional full pause mid-phase
				if ($urandom_range(0, 63) == 0)
					drain();
				send_item(pick_age(), 16'($urandom));
				rand_items++;
			end
		end

		drain();
		repeat (TailCycles) @(posedge clk);

		$display("Covered %0d items over %0d config phases, %0d register writes,",
			tracker.noted, phases + 5, config_writes);
		$display("%0d color words checked, %0d full drains, %0d errors.",
			tracker.checked, drains, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
